// ===== src/gregorian_date_add_days_unit_assert.svh =====
// assertion macros for the date adder
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define GDAD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define GDAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define GDAD_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define GDAD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/gdad_pkg.sv =====
`timescale 1ns / 1ps

package gdad_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 15;
   localparam int DAYS_W  = 15;
   localparam int MOD_W   = 9;
   localparam int QUOT_W  = 7;
   localparam int LEN_W   = 9;

   localparam logic [YEAR_W-1:0] YEAR_MAX = 15'd32767;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0] DAY_LAST  = 5'd31;

   // year / 400 by reciprocal, exact for 15-bit years
   localparam logic [12:0] RECIP_400   = 13'd5243;
   localparam int          RECIP_SHIFT = 21;
   localparam logic [YEAR_W-1:0] CYCLE_YEARS = 15'd400;

   localparam logic [MOD_W-1:0] MOD_LAST    = 9'd399;
   localparam logic [MOD_W-1:0] CENTURY_ONE = 9'd100;
   localparam logic [MOD_W-1:0] CENTURY_TWO = 9'd200;
   localparam logic [MOD_W-1:0] CENTURY_THR = 9'd300;

   localparam logic [LEN_W-1:0] YEAR_LEN_LEAP   = 9'd366;
   localparam logic [LEN_W-1:0] YEAR_LEN_COMMON = 9'd365;

   typedef struct packed {
      logic load;
      logic reduce;
      logic fold;
      logic check;
      logic step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic finished;
   } stat_type;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== src/gregorian_date_add_days_unit.sv =====
`timescale 1ns / 1ps
// date adder: moves a gregorian date forward by a count of days
// req channel: one item is a start date and a day count, taken when the unit is idle
// rsp channel: one item per request, the resulting date and a status
//    status ok, invalid start date (passed through), or year overflow (saturated)
// sequence: setup (year mod 400 by reciprocal, check), then month steps or whole-year
//    skips until the count runs out, then the load of the output register once it
//    is free
// the length of a request is set by the step loop: up to twelve months to reach
//    january, up to 89 year skips, up to eleven more months and a last partial month
// a new request is taken only after the previous result is in the output register
// the output register holds its item while rsp_tready is low; the next result
//    waits in the datapath until the register frees
// reset (synchronous) returns the controller to idle and drops rsp_tvalid;
//    no memory, nothing to clear

module gregorian_date_add_days_unit import gdad_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // day_in, month_in, year_in, days_to_add, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // day_out, month_out, year_out
   output logic [1:0]  rsp_tuser    // status
);

   cmd_type            cmd;
   stat_type           stat;
   logic [DAY_W-1:0]   day_out;
   logic [MONTH_W-1:0] month_out;
   logic [YEAR_W-1:0]  year_out;

   gdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   gdad_datapath u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .stat        (stat),
      .day_in      (req_tdata[4:0]),
      .month_in    (req_tdata[8:5]),
      .year_in     (req_tdata[23:9]),
      .days_to_add (req_tdata[38:24]),
      .day_out     (day_out),
      .month_out   (month_out),
      .year_out    (year_out),
      .status      (rsp_tuser)
   );

   assign rsp_tdata = {year_out, month_out, day_out};

endmodule

// ===== src/gdad_datapath.sv =====
`timescale 1ns / 1ps

module gdad_datapath import gdad_pkg::*; (
   input  logic                 clock,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [DAY_W-1:0]     day_in,
   input  logic [MONTH_W-1:0]   month_in,
   input  logic [YEAR_W-1:0]    year_in,
   input  logic [DAYS_W-1:0]    days_to_add,
   output logic [DAY_W-1:0]     day_out,
   output logic [MONTH_W-1:0]   month_out,
   output logic [YEAR_W-1:0]    year_out,
   output logic [1:0]           status
);

   logic [DAY_W-1:0]   day_ff, day_in_w;
   logic [MONTH_W-1:0] month_ff, month_in_w;
   logic [YEAR_W-1:0]  year_ff, year_in_w;
   logic [DAYS_W-1:0]  rem_ff, rem_in;
   logic [MOD_W-1:0]   mod_ff, mod_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [1:0]         status_ff, status_in;

   logic [DAY_W-1:0]   day_out_ff, day_out_in;
   logic [MONTH_W-1:0] month_out_ff, month_out_in;
   logic [YEAR_W-1:0]  year_out_ff, year_out_in;
   logic [1:0]         status_out_ff, status_out_in;

   logic [27:0]        recip_prod;
   logic [YEAR_W-1:0]  cycle_base;
   logic [YEAR_W-1:0]  year_diff;
   logic               leap;
   logic [DAY_W-1:0]   mlen;
   logic [LEN_W-1:0]   ylen;
   logic [DAYS_W:0]    day_sum;
   logic [DAY_W-1:0]   month_rest;
   logic [MOD_W-1:0]   mod_next;
   logic               finished;
   logic               date_ok;

   assign recip_prod = {13'd0, year_ff} * {15'd0, RECIP_400};
   assign cycle_base = {8'd0, quot_ff} * CYCLE_YEARS;
   assign year_diff  = year_ff - cycle_base;

   assign leap = (mod_ff[1:0] == 2'd0) && (mod_ff != CENTURY_ONE) &&
                 (mod_ff != CENTURY_TWO) && (mod_ff != CENTURY_THR);
   assign mlen = month_length(month_ff, leap);
   assign ylen = leap ? YEAR_LEN_LEAP : YEAR_LEN_COMMON;

   assign day_sum    = {11'd0, day_ff} + {1'b0, rem_ff};
   assign month_rest = mlen - day_ff + DAY_FIRST;
   assign mod_next   = (mod_ff == MOD_LAST) ? '0 : mod_ff + 9'd1;

   assign date_ok = (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                    (day_ff >= DAY_FIRST) && (day_ff <= mlen);

   assign finished      = (status_ff != STATUS_OK) || (rem_ff == '0);
   assign stat.finished = finished;

   always_comb begin
      day_in_w   = day_ff;
      month_in_w = month_ff;
      year_in_w  = year_ff;
      rem_in     = rem_ff;
      mod_in     = mod_ff;
      quot_in    = quot_ff;
      status_in  = status_ff;
      if (cmd.load) begin
         day_in_w   = day_in;
         month_in_w = month_in;
         year_in_w  = year_in;
         rem_in     = days_to_add;
         status_in  = STATUS_OK;
      end
      if (cmd.reduce) begin
         quot_in = recip_prod[27:RECIP_SHIFT];
      end
      if (cmd.fold) begin
         mod_in = year_diff[MOD_W-1:0];
      end
      if (cmd.check && !date_ok) begin
         status_in = STATUS_INVALID;
      end
      if (cmd.step && !finished) begin
         if ((month_ff == MONTH_JAN) && (day_ff == DAY_FIRST) &&
             (rem_ff >= {6'd0, ylen})) begin
            // whole year from the first of january
            if (year_ff == YEAR_MAX) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               year_in_w = year_ff + 15'd1;
               mod_in    = mod_next;
               rem_in    = rem_ff - {6'd0, ylen};
            end
         end else if (day_sum <= {11'd0, mlen}) begin
            day_in_w = day_sum[DAY_W-1:0];
            rem_in   = '0;
         end else begin
            rem_in   = rem_ff - {10'd0, month_rest};
            day_in_w = DAY_FIRST;
            if (month_ff == MONTH_DEC) begin
               month_in_w = MONTH_JAN;
               if (year_ff == YEAR_MAX) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  year_in_w = year_ff + 15'd1;
                  mod_in    = mod_next;
               end
            end else begin
               month_in_w = month_ff + 4'd1;
            end
         end
      end
   end

   always_comb begin
      day_out_in    = day_out_ff;
      month_out_in  = month_out_ff;
      year_out_in   = year_out_ff;
      status_out_in = status_out_ff;
      if (cmd.out_load) begin
         status_out_in = status_ff;
         if (status_ff == STATUS_OVERFLOW) begin
            day_out_in   = DAY_LAST;
            month_out_in = MONTH_DEC;
            year_out_in  = YEAR_MAX;
         end else begin
            day_out_in   = day_ff;
            month_out_in = month_ff;
            year_out_in  = year_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      day_ff        <= day_in_w;
      month_ff      <= month_in_w;
      year_ff       <= year_in_w;
      rem_ff        <= rem_in;
      mod_ff        <= mod_in;
      quot_ff       <= quot_in;
      status_ff     <= status_in;
      day_out_ff    <= day_out_in;
      month_out_ff  <= month_out_in;
      year_out_ff   <= year_out_in;
      status_out_ff <= status_out_in;
   end

   assign day_out   = day_out_ff;
   assign month_out = month_out_ff;
   assign year_out  = year_out_ff;
   assign status    = status_out_ff;

endmodule

// ===== src/gdad_ctrl.sv =====
`timescale 1ns / 1ps
`include "gregorian_date_add_days_unit_assert.svh"

module gdad_ctrl import gdad_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output cmd_type  cmd,
   input  stat_type stat
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_MOD    = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_STEP   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.reduce = 1'b1;
            state_in   = ST_MOD;
         end
         ST_MOD: begin
            cmd.fold = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (stat.finished) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GDAD_ASSERT_NEXT(accept_starts_div, clock, reset, req_tvalid && req_tready, state_ff == ST_DIV)
   `GDAD_ASSERT_IMP(load_into_free_output, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_tready)
   `GDAD_ASSERT_NEXT(load_shows_result, clock, reset, cmd.out_load, rsp_valid_ff)
   `GDAD_ASSERT_IMP(step_only_when_open, clock, reset, cmd.step, !stat.finished)

endmodule
